// ===== design/stbs_pkg.sv =====
package stbs_pkg;

	localparam int SLOT_BITS = 10;
	localparam int KEY_BITS = 32;
	localparam int CFG_W = 11;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int WRAP_SHIFT_MAX = 9;
	localparam int WRAP_K_W = 4;

	localparam logic [CFG_W-1:0] ENTRIES_RESET = 11'd1024;
	localparam logic [WRAP_K_W-1:0] WRAP_K_START = 4'd9;

	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// word index bit of paddr
	localparam logic REG_ENTRIES_IN_USE = 1'b0;

	typedef struct packed {
		logic kind;
		logic [SLOT_BITS-1:0] slot;
		logic signed [KEY_BITS-1:0] entry_value;
		logic signed [KEY_BITS-1:0] search_key;
		logic [SLOT_BITS-1:0] search_low;
		logic [SLOT_BITS-1:0] search_high;
	} item_t;

	typedef struct packed {
		logic found;
		logic [SLOT_BITS-1:0] position;
		logic range_error;
	} result_t;

	typedef struct packed {
		logic capture;
		logic wrap_step;
		logic write_entry;
		logic start;
		logic probe;
		logic publish;
	} dp_cmd_t;

	typedef struct packed {
		logic item_is_query;
		logic slot_in_range;
		logic start_end;
		logic probe_end;
	} dp_status_t;

endpackage

// ===== design/stbs_datapath.sv =====
module stbs_datapath import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input item_t item,
	input logic [CFG_W-1:0] entries_in_use,
	input dp_cmd_t cmd,
	output dp_status_t status,
	output result_t result
);

	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int SHW = $clog2(TABLE_DEPTH + 1) + WRAP_SHIFT_MAX + 1;
	localparam int UW = $clog2(TABLE_DEPTH + 1) + CFG_W;

	logic [VALUE_BITS-1:0] table_q [TABLE_DEPTH];
	logic [VALUE_BITS-1:0] value_q;
	logic [VALUE_BITS-1:0] key_q;
	logic [VALUE_BITS-1:0] rdata_q;
	logic [SLOT_BITS-1:0] slot_q;
	logic [SLOT_BITS-1:0] lo_q;
	logic [SLOT_BITS-1:0] hi_q;
	logic [SLOT_BITS-1:0] mid_q;
	logic [WRAP_K_W-1:0] k_q;
	logic res_found_q;
	logic [SLOT_BITS-1:0] res_pos_q;
	logic res_rerr_q;
	result_t result_q;

	logic [SLOT_BITS:0] sum_start;
	logic [SLOT_BITS:0] sum_lower;
	logic [SLOT_BITS:0] sum_upper;
	logic [SLOT_BITS-1:0] mid_start;
	logic [SLOT_BITS-1:0] mid_lower;
	logic [SLOT_BITS-1:0] mid_upper;
	logic [SLOT_BITS-1:0] next_mid;
	logic [AW-1:0] rd_addr;
	logic entry_gt;
	logic entry_eq;
	logic range_err;
	logic [SHW-1:0] slot_ext;
	logic [SHW-1:0] wrap_limit;

	function automatic logic [VALUE_BITS-1:0] to_entry(input logic [KEY_BITS-1:0] v);
		logic signed [VALUE_BITS+KEY_BITS-1:0] ext;
		ext = (VALUE_BITS + KEY_BITS)'(signed'(v));
		return ext[VALUE_BITS-1:0];
	endfunction

	always_comb begin
		sum_start = {1'b0, lo_q} + {1'b0, hi_q};
		sum_lower = {1'b0, lo_q} + {1'b0, mid_q} - {{SLOT_BITS{1'b0}}, 1'b1};
		sum_upper = {1'b0, mid_q} + {1'b0, hi_q} + {{SLOT_BITS{1'b0}}, 1'b1};
		mid_start = sum_start[SLOT_BITS:1];
		mid_lower = sum_lower[SLOT_BITS:1];
		mid_upper = sum_upper[SLOT_BITS:1];
		entry_gt = $signed(rdata_q) > $signed(key_q);
		entry_eq = rdata_q == key_q;
		next_mid = entry_gt ? mid_lower : mid_upper;
		rd_addr = cmd.start ? AW'(mid_start) : AW'(next_mid);
		range_err = (UW'(hi_q) >= UW'(entries_in_use)) || (UW'(hi_q) >= UW'(TABLE_DEPTH));
		slot_ext = SHW'(slot_q);
		wrap_limit = SHW'(TABLE_DEPTH) << k_q;
	end

	assign status.item_is_query = item.kind == KIND_QUERY;
	assign status.slot_in_range = slot_ext < SHW'(TABLE_DEPTH);
	assign status.start_end = range_err || (lo_q > hi_q);
	assign status.probe_end = entry_eq || (entry_gt ? (mid_q == lo_q) : (mid_q == hi_q));
	assign result = result_q;

	// table memory, one write and one registered read port
	always_ff @(posedge clk) begin
		if (cmd.write_entry) begin
			table_q[AW'(slot_q)] <= value_q;
		end
		rdata_q <= table_q[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			slot_q <= item.slot;
			value_q <= to_entry(item.entry_value);
			key_q <= to_entry(item.search_key);
			lo_q <= item.search_low;
			hi_q <= item.search_high;
			k_q <= WRAP_K_START;
			res_found_q <= 1'b0;
			res_pos_q <= '0;
			res_rerr_q <= 1'b0;
		end
		if (cmd.wrap_step) begin
			if (slot_ext >= wrap_limit) begin
				slot_q <= SLOT_BITS'(slot_ext - wrap_limit);
			end
			k_q <= k_q - 1'b1;
		end
		if (cmd.start) begin
			res_rerr_q <= range_err;
			mid_q <= mid_start;
		end
		if (cmd.probe) begin
			if (entry_eq) begin
				res_found_q <= 1'b1;
				res_pos_q <= mid_q;
			end else if (entry_gt) begin
				hi_q <= mid_q - 1'b1;
				mid_q <= mid_lower;
			end else begin
				lo_q <= mid_q + 1'b1;
				mid_q <= mid_upper;
			end
		end
		if (cmd.publish) begin
			result_q.found <= res_found_q;
			result_q.position <= res_pos_q;
			result_q.range_error <= res_rerr_q;
		end
	end

endmodule

// ===== design/stbs_ctrl.sv =====
module stbs_ctrl import stbs_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	output logic result_valid,
	input logic result_stall,
	input dp_status_t status,
	output dp_cmd_t cmd
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_LOAD = 3'd1;
	localparam logic [2:0] ST_START = 3'd2;
	localparam logic [2:0] ST_PROBE = 3'd3;
	localparam logic [2:0] ST_DONE = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic result_valid_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		item_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				if (item_valid) begin
					cmd.capture = 1'b1;
					state_d = status.item_is_query ? ST_START : ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (status.slot_in_range) begin
					cmd.write_entry = 1'b1;
					state_d = ST_IDLE;
				end else begin
					cmd.wrap_step = 1'b1;
				end
			end
			ST_START: begin
				cmd.start = 1'b1;
				state_d = status.start_end ? ST_DONE : ST_PROBE;
			end
			ST_PROBE: begin
				cmd.probe = 1'b1;
				if (status.probe_end) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!result_valid_q || !result_stall) begin
					cmd.publish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				result_valid_q <= 1'b1;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign result_valid = result_valid_q;

endmodule

// ===== design/sorted_table_binary_search.sv =====
// channel   direction  handshake                  payload
// item      in         item_valid / item_stall    item_t (load or query)
// result    out        result_valid / result_stall result_t (one per query)
// apb       in/out     psel penable pwrite pready entries_in_use at byte 0
//
// a load is captured, then written to its slot; with a table shallower than 1024 an out-of-range slot
// is first folded by one restoring subtract step a cycle
// a query is captured, started, then makes p probes of at most log2(TABLE_DEPTH) + 1, one
// per cycle, set by the single registered read port of the table memory
// the table is not cleared by reset; arst_n resets control, entries_in_use to 1024
// a finished result sits in the output register while the next item is taken
module sorted_table_binary_search import stbs_pkg::*; #(
	parameter int TABLE_DEPTH = 1024,
	parameter int VALUE_BITS = 32
) (
	input logic clk,
	input logic arst_n,
	input logic item_valid,
	output logic item_stall,
	input item_t item,
	output logic result_valid,
	input logic result_stall,
	output result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	logic [CFG_W-1:0] entries_q;
	dp_cmd_t cmd;
	dp_status_t status;
	logic sel_entries;

	assign sel_entries = paddr[PADDR_W-1] == REG_ENTRIES_IN_USE;
	assign pready = 1'b1;
	assign prdata = sel_entries ? PDATA_W'(entries_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entries_q <= ENTRIES_RESET;
		end else if (psel && penable && pwrite && sel_entries) begin
			entries_q <= pwdata[CFG_W-1:0];
		end
	end

	stbs_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.status(status),
		.cmd(cmd)
	);

	stbs_datapath #(
		.TABLE_DEPTH(TABLE_DEPTH),
		.VALUE_BITS(VALUE_BITS)
	) u_datapath (
		.clk(clk),
		.item(item),
		.entries_in_use(entries_q),
		.cmd(cmd),
		.status(status),
		.result(result)
	);

	a_found_in_use: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.found) |-> ({1'b0, result.position} < entries_q))
		else $error("found position outside entries in use");

	a_error_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result.found && result.range_error))
		else $error("range error reported with a match");

	a_miss_zero_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.found) |-> (result.position == '0))
		else $error("miss with nonzero position");

	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(item_valid && !item_stall && item.kind == KIND_QUERY) |=> item_stall)
		else $error("transaction taken during a search");

endmodule
